// File: hw/rtl/wtsu_pkg.sv
// Shared types and constants for the Wilson-theta state update block.
// Depends on nothing; every other file of the block but wtsu_ram uses it.
`timescale 1ns / 1ps

package wtsu_pkg;

  localparam int DATA_W        = 32;
  localparam int DOF_W         = 10;
  localparam int CFG_IDX_W     = 3;
  localparam int STEP_W        = 3;
  localparam int FRAC_BITS     = 16;
  localparam int DOF_DEPTH_DEF = 1024;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_PREDICT = 2'd1,
    KIND_CORRECT = 2'd2,
    KIND_COMMIT  = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_THETA     = 3'd0,
    REG_PRED_VEL_COEF = 3'd1,
    REG_PRED_ACC_COEF = 3'd2,
    REG_VEL_GAIN      = 3'd3,
    REG_ACC_GAIN      = 3'd4,
    REG_HALF_DT       = 3'd5,
    REG_STEP_DT       = 3'd6,
    REG_DT_SQ_SIXTH   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    kind_e                    kind;
    logic [DOF_W-1:0]         dof;
    logic signed [DATA_W-1:0] disp_value;
    logic signed [DATA_W-1:0] vel_value;
    logic signed [DATA_W-1:0] acc_value;
  } in_item_t;

  typedef struct packed {
    logic [DOF_W-1:0]         dof_out;
    logic signed [DATA_W-1:0] disp_out;
    logic signed [DATA_W-1:0] vel_out;
    logic signed [DATA_W-1:0] acc_out;
    logic                     saturated;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic              accept;
    logic              run;
    logic [STEP_W-1:0] step;
    logic              wr;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic dof_ok;
    logic last_step;
  } status_t;

endpackage

// File: hw/rtl/wtsu_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module wtsu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/wtsu_ctrl.sv
// Sequencer for the state update: accept, step through the multiply
// schedule, write back. Depends on wtsu_pkg.
`timescale 1ns / 1ps

module wtsu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  wtsu_pkg::status_t status_i,
  output wtsu_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_WRITE = 3'b100
  } state_e;

  state_e                      state_q, state_d;
  logic [wtsu_pkg::STEP_W-1:0] step_q, step_d;
  logic                        out_valid_q, out_valid_d;

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    in_ready_o   = 1'b0;
    cmd_o.accept = 1'b0;
    cmd_o.run    = 1'b0;
    cmd_o.step   = step_q;
    cmd_o.wr     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        step_d       = '0;
        // drop a request whose index lies beyond the store
        if (in_valid_i && status_i.dof_ok) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        cmd_o.run = 1'b1;
        if (status_i.last_step) begin
          state_d = S_WRITE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_WRITE: begin
        // hold until the output slot is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.wr = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.wr;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: hw/rtl/wtsu_datapath.sv
// Datapath: six per-DOF memories, step registers, one shared multiplier
// with rounding, three wide accumulators and the output register.
// Depends on wtsu_pkg and wtsu_ram.
`timescale 1ns / 1ps

module wtsu_datapath #(
  parameter int DOF_DEPTH = wtsu_pkg::DOF_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  wtsu_pkg::in_item_t               in_data_i,
  input  logic                             cfg_we_i,
  input  logic [wtsu_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [wtsu_pkg::DATA_W-1:0]      cfg_data_i,
  input  wtsu_pkg::cmd_t                   cmd_i,
  output wtsu_pkg::status_t                status_o,
  output wtsu_pkg::out_item_t              out_data_o
);

  localparam int AW     = (DOF_DEPTH > 1) ? $clog2(DOF_DEPTH) : 1;
  localparam int DW     = wtsu_pkg::DATA_W;
  localparam int FB     = wtsu_pkg::FRAC_BITS;
  localparam int PW     = 2 * DW + 1;
  localparam int RW     = PW + 1;
  localparam int ACC_W  = 68;
  localparam logic [wtsu_pkg::STEP_W-1:0] LAST_LOAD   = 3'd0;
  localparam logic [wtsu_pkg::STEP_W-1:0] LAST_UPDATE = 3'd2;
  localparam logic [wtsu_pkg::STEP_W-1:0] LAST_COMMIT = 3'd6;
  localparam logic [DW-1:0] INV_THETA_RST = DW'(64'd1 << FB);

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_D    = 2'd1,
    TGT_V    = 2'd2,
    TGT_A    = 2'd3
  } tgt_e;

  function automatic logic signed [ACC_W-1:0] ext_acc(input logic [DW-1:0] x);
    return $signed({{(ACC_W-DW){x[DW-1]}}, x});
  endfunction

  function automatic logic signed [DW:0] ext_op(input logic [DW-1:0] x);
    return $signed({x[DW-1], x});
  endfunction

  // {clip flag, clipped value}
  function automatic logic [DW:0] sat32(input logic signed [ACC_W-1:0] v);
    logic in_range;
    in_range = (&v[ACC_W-1:DW-1]) || !(|v[ACC_W-1:DW-1]);
    if (in_range) begin
      return {1'b0, v[DW-1:0]};
    end
    return {1'b1, v[ACC_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}}};
  endfunction

  // Configuration registers
  logic [DW-1:0] inv_theta_q, pred_vel_coef_q, pred_acc_coef_q, vel_gain_q;
  logic [DW-1:0] acc_gain_q, half_dt_q, step_dt_q, dt_sq_sixth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_theta_q     <= INV_THETA_RST;
      pred_vel_coef_q <= '0;
      pred_acc_coef_q <= '0;
      vel_gain_q      <= '0;
      acc_gain_q      <= '0;
      half_dt_q       <= '0;
      step_dt_q       <= '0;
      dt_sq_sixth_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (wtsu_pkg::cfg_reg_e'(cfg_index_i))
        wtsu_pkg::REG_INV_THETA:     inv_theta_q     <= cfg_data_i;
        wtsu_pkg::REG_PRED_VEL_COEF: pred_vel_coef_q <= cfg_data_i;
        wtsu_pkg::REG_PRED_ACC_COEF: pred_acc_coef_q <= cfg_data_i;
        wtsu_pkg::REG_VEL_GAIN:      vel_gain_q      <= cfg_data_i;
        wtsu_pkg::REG_ACC_GAIN:      acc_gain_q      <= cfg_data_i;
        wtsu_pkg::REG_HALF_DT:       half_dt_q       <= cfg_data_i;
        wtsu_pkg::REG_STEP_DT:       step_dt_q       <= cfg_data_i;
        wtsu_pkg::REG_DT_SQ_SIXTH:   dt_sq_sixth_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Request registers
  wtsu_pkg::kind_e        kind_q;
  logic [wtsu_pkg::DOF_W-1:0] dof_q;
  logic [DW-1:0]          dv_q, vv_q, av_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= in_data_i.kind;
      dof_q  <= in_data_i.dof;
      dv_q   <= in_data_i.disp_value;
      vv_q   <= in_data_i.vel_value;
      av_q   <= in_data_i.acc_value;
    end
  end

  assign status_o.dof_ok = 32'(in_data_i.dof) < 32'(DOF_DEPTH);

  always_comb begin
    case (kind_q)
      wtsu_pkg::KIND_LOAD:   status_o.last_step = (cmd_i.step == LAST_LOAD);
      wtsu_pkg::KIND_COMMIT: status_o.last_step = (cmd_i.step == LAST_COMMIT);
      default:               status_o.last_step = (cmd_i.step == LAST_UPDATE);
    endcase
  end

  // Per-DOF stores
  logic [DW-1:0] td, tv, ta, cd, cv, ca;
  logic [DW-1:0] res_d, res_v, res_a;
  logic          sat_d, sat_v, sat_a;
  logic          we_trial, we_comm;
  logic [AW-1:0] raddr, waddr;

  assign raddr    = AW'(in_data_i.dof);
  assign waddr    = AW'(dof_q);
  assign we_trial = cmd_i.wr;
  assign we_comm  = cmd_i.wr && (kind_q == wtsu_pkg::KIND_PREDICT);

  wtsu_ram #(.WIDTH(DW), .DEPTH(DOF_DEPTH)) u_trial_disp (
    .clk_i, .we_i(we_trial), .waddr_i(waddr), .wdata_i(res_d),
    .re_i(cmd_i.accept), .raddr_i(raddr), .rdata_o(td));
  wtsu_ram #(.WIDTH(DW), .DEPTH(DOF_DEPTH)) u_trial_vel (
    .clk_i, .we_i(we_trial), .waddr_i(waddr), .wdata_i(res_v),
    .re_i(cmd_i.accept), .raddr_i(raddr), .rdata_o(tv));
  wtsu_ram #(.WIDTH(DW), .DEPTH(DOF_DEPTH)) u_trial_acc (
    .clk_i, .we_i(we_trial), .waddr_i(waddr), .wdata_i(res_a),
    .re_i(cmd_i.accept), .raddr_i(raddr), .rdata_o(ta));
  wtsu_ram #(.WIDTH(DW), .DEPTH(DOF_DEPTH)) u_comm_disp (
    .clk_i, .we_i(we_comm), .waddr_i(waddr), .wdata_i(td),
    .re_i(cmd_i.accept), .raddr_i(raddr), .rdata_o(cd));
  wtsu_ram #(.WIDTH(DW), .DEPTH(DOF_DEPTH)) u_comm_vel (
    .clk_i, .we_i(we_comm), .waddr_i(waddr), .wdata_i(tv),
    .re_i(cmd_i.accept), .raddr_i(raddr), .rdata_o(cv));
  wtsu_ram #(.WIDTH(DW), .DEPTH(DOF_DEPTH)) u_comm_acc (
    .clk_i, .we_i(we_comm), .waddr_i(waddr), .wdata_i(ta),
    .re_i(cmd_i.accept), .raddr_i(raddr), .rdata_o(ca));

  // Multiply schedule
  logic signed [DW-1:0] mul_a;
  logic signed [DW:0]   mul_b;
  logic                 mul_extra;
  tgt_e                 mul_tgt, tgt_q;
  logic                 extra_q;
  logic signed [PW-1:0] p_q;
  logic [DW-1:0]        ta_new_q;
  logic signed [DW:0]   acc_diff;

  assign acc_diff = ext_op(ta) - ext_op(ca);

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mul_extra = 1'b0;
    mul_tgt   = TGT_NONE;
    case (kind_q)
      wtsu_pkg::KIND_PREDICT: begin
        case (cmd_i.step)
          3'd0: begin mul_a = pred_vel_coef_q; mul_b = ext_op(ta); mul_tgt = TGT_V; end
          3'd1: begin mul_a = pred_acc_coef_q; mul_b = ext_op(tv); mul_tgt = TGT_A; end
          default: ;
        endcase
      end
      wtsu_pkg::KIND_CORRECT: begin
        case (cmd_i.step)
          3'd0: begin mul_a = vel_gain_q; mul_b = ext_op(dv_q); mul_tgt = TGT_V; end
          3'd1: begin mul_a = acc_gain_q; mul_b = ext_op(dv_q); mul_tgt = TGT_A; end
          default: ;
        endcase
      end
      wtsu_pkg::KIND_COMMIT: begin
        case (cmd_i.step)
          3'd0: begin mul_a = inv_theta_q; mul_b = acc_diff; mul_tgt = TGT_A; end
          3'd1: begin mul_a = half_dt_q; mul_b = ext_op(ca); mul_tgt = TGT_V; end
          3'd2: begin mul_a = step_dt_q; mul_b = ext_op(cv); mul_tgt = TGT_D; end
          3'd3: begin
            // twice dt^2/6 times the old acceleration: one less shift
            mul_a = dt_sq_sixth_q; mul_b = ext_op(ca); mul_extra = 1'b1;
            mul_tgt = TGT_D;
          end
          3'd4: begin mul_a = half_dt_q; mul_b = ext_op(ta_new_q); mul_tgt = TGT_V; end
          3'd5: begin mul_a = dt_sq_sixth_q; mul_b = ext_op(ta_new_q); mul_tgt = TGT_D; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q <= TGT_NONE;
    end else begin
      tgt_q <= cmd_i.run ? mul_tgt : TGT_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.run && (mul_tgt != TGT_NONE)) begin
      p_q     <= mul_a * mul_b;
      extra_q <= mul_extra;
    end
  end

  // Round to nearest, ties up
  logic signed [RW-1:0] p_ext, p_sh, rnd;
  logic signed [ACC_W-1:0] rnd_acc;

  assign p_ext   = $signed({p_q[PW-1], p_q});
  assign p_sh    = extra_q ? (p_ext >>> (FB - 2)) : (p_ext >>> (FB - 1));
  assign rnd     = (p_sh + RW'(1)) >>> 1;
  assign rnd_acc = $signed({{(ACC_W-RW){rnd[RW-1]}}, rnd});

  // Accumulators
  logic signed [ACC_W-1:0] acc_d_q, acc_v_q, acc_a_q;
  logic [DW:0] sat_res_d, sat_res_v, sat_res_a;

  always_ff @(posedge clk_i) begin
    if (cmd_i.run) begin
      if (cmd_i.step == '0) begin
        case (kind_q)
          wtsu_pkg::KIND_LOAD: begin
            acc_d_q <= ext_acc(dv_q);
            acc_v_q <= ext_acc(vv_q);
            acc_a_q <= ext_acc(av_q);
          end
          wtsu_pkg::KIND_PREDICT: begin
            acc_d_q <= ext_acc(td);
            acc_v_q <= -(ext_acc(tv) <<< 1);
            acc_a_q <= -(ext_acc(ta) <<< 1);
          end
          wtsu_pkg::KIND_CORRECT: begin
            acc_d_q <= ext_acc(td) + ext_acc(dv_q);
            acc_v_q <= ext_acc(tv);
            acc_a_q <= ext_acc(ta);
          end
          default: begin
            acc_d_q <= ext_acc(cd);
            acc_v_q <= ext_acc(cv);
            acc_a_q <= ext_acc(ca);
          end
        endcase
      end else begin
        case (tgt_q)
          TGT_D:   acc_d_q <= acc_d_q + rnd_acc;
          TGT_V:   acc_v_q <= acc_v_q + rnd_acc;
          TGT_A:   acc_a_q <= acc_a_q + rnd_acc;
          default: ;
        endcase
      end
      // the new acceleration is final once the first term is in
      if (cmd_i.step == 3'd2) begin
        ta_new_q <= sat_res_a[DW-1:0];
      end
    end
  end

  assign sat_res_d = sat32(acc_d_q);
  assign sat_res_v = sat32(acc_v_q);
  assign sat_res_a = sat32(acc_a_q);
  assign {sat_d, res_d} = sat_res_d;
  assign {sat_v, res_v} = sat_res_v;
  assign {sat_a, res_a} = sat_res_a;

  // Output register
  wtsu_pkg::out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      out_q.dof_out   <= dof_q;
      out_q.disp_out  <= res_d;
      out_q.vel_out   <= res_v;
      out_q.acc_out   <= res_a;
      out_q.saturated <= sat_d | sat_v | sat_a;
    end
  end

  assign out_data_o = out_q;

endmodule

// File: hw/rtl/wilson_theta_state_update.sv
// Top level of the Wilson-theta state update block.
// Depends on wtsu_pkg, wtsu_ctrl, wtsu_datapath and wtsu_ram.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one request:
//   an operation kind (load, predict, correct, commit), a DOF index and up
//   to three Q16.16 values. Output channel (out_valid_o / out_ready_i /
//   out_data_o) returns the new trial displacement, velocity, acceleration
//   and a clip flag for that DOF. Configuration writes (cfg_valid_i,
//   cfg_index_i, cfg_data_i) set the eight step constants; cfg_ready_o is
//   always high, and writes belong in idle periods only.
//   One request is in work at a time; the next is taken only after the
//   result is registered. The time a request takes is set by the single
//   shared 32x33 multiplier, stepped through the products of the operation,
//   so load is the quickest and commit the slowest.
//   A request whose index is beyond the store is dropped with no result.
//   The result sits in an output register: while the receiver stalls, a
//   new request is still accepted and worked, and holds at write-back
//   until the register frees. Reset clears the sequencer, the output valid
//   and the constants (inv_theta to one); the stores are undefined until
//   loaded.

module wilson_theta_state_update #(
  parameter int DOF_DEPTH = wtsu_pkg::DOF_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  wtsu_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output wtsu_pkg::out_item_t            out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wtsu_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [wtsu_pkg::DATA_W-1:0]    cfg_data_i
);

  wtsu_pkg::cmd_t    cmd;
  wtsu_pkg::status_t status;

  // configuration registers take a write in any cycle
  assign cfg_ready_o = 1'b1;

  wtsu_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .out_valid_o,
    .out_ready_i,
    .status_i (status),
    .cmd_o    (cmd)
  );

  wtsu_datapath #(.DOF_DEPTH(DOF_DEPTH)) u_datapath (
    .clk_i,
    .rst_ni,
    .in_data_i,
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o
  );

endmodule

// File: hw/rtl/wtsu_checker.sv
// Port-level checks for the state update block, bound to the top level.
// Depends on wtsu_pkg and wilson_theta_state_update.
`timescale 1ns / 1ps

module wtsu_checker #(
  parameter int DOF_DEPTH = wtsu_pkg::DOF_DEPTH_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input wtsu_pkg::in_item_t             in_data_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input wtsu_pkg::out_item_t            out_data_o,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o
);

  logic in_taken;
  assign in_taken = in_valid_i && in_ready_o && (32'(in_data_i.dof) < 32'(DOF_DEPTH));

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // a request in work keeps the input closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_taken |=> !in_ready_o ##1 !in_ready_o)
    else $error("input reopened while a request is in work");

  // a new result appears only out of write-back, when input was closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result without a request in work");

  // configuration is never back-pressured
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind wilson_theta_state_update wtsu_checker #(.DOF_DEPTH(DOF_DEPTH)) u_checker (.*);

// File: bench/wtsu_state_checker.sv
`timescale 1ns / 1ps
// Checker for wilson_theta_state_update: keeps its own copy of the per-DOF
// trial/committed state and the step constants, and compares every result.
// Depends on wtsu_pkg for the request, result and register types.

module wtsu_state_checker #(
  parameter int DOF_DEPTH = wtsu_pkg::DOF_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  wtsu_pkg::in_item_t             in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  wtsu_pkg::out_item_t            out_data_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [wtsu_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [wtsu_pkg::DATA_W-1:0]    cfg_data_i,
  output int                             fail_count_o,
  output int                             waiting_o
);
  import wtsu_pkg::*;

  typedef logic signed [79:0]       wide_t;
  typedef logic signed [DATA_W-1:0] q_t;

  localparam wide_t WIDE_MAX = 80'sh7FFF_FFFF;
  localparam wide_t WIDE_MIN = -80'sh8000_0000;

  q_t tr_disp [DOF_DEPTH];
  q_t tr_vel  [DOF_DEPTH];
  q_t tr_acc  [DOF_DEPTH];
  q_t cm_disp [DOF_DEPTH];
  q_t cm_vel  [DOF_DEPTH];
  q_t cm_acc  [DOF_DEPTH];
  q_t coef    [8];

  out_item_t expected_updates [$];
  int        fail_count = 0;
  int        waiting = 0;

  assign fail_count_o = fail_count;
  assign waiting_o    = waiting;

  // Product shifted down to Q16.16, rounded to nearest with ties up.
  // extra = 1 doubles the product before rounding.
  function automatic wide_t scaled(input wide_t a, input wide_t b, input int unsigned extra);
    wide_t prod;
    prod = a * b;
    return ((prod >>> (FRAC_BITS - 1 - extra)) + 1) >>> 1;
  endfunction

  // Clip to 32 bits; the top bit of the return flags a clip.
  function automatic logic [DATA_W:0] clip(input wide_t v);
    if (v > WIDE_MAX) return {1'b1, 32'h7FFF_FFFF};
    if (v < WIDE_MIN) return {1'b1, 32'h8000_0000};
    return {1'b0, v[DATA_W-1:0]};
  endfunction

  function automatic bit next_trial_values(input in_item_t req, output out_item_t res);
    int unsigned    i;
    wide_t          cd, cv, ca, ta, d;
    logic [DATA_W:0] r;
    logic           sat;
    res = '0;
    if (req.dof >= DOF_DEPTH) return 1'b0;
    i   = req.dof;
    sat = 1'b0;
    case (req.kind)
      KIND_LOAD: begin
        tr_disp[i] = req.disp_value;
        tr_vel[i]  = req.vel_value;
        tr_acc[i]  = req.acc_value;
      end
      KIND_PREDICT: begin
        cm_disp[i] = tr_disp[i];
        cm_vel[i]  = tr_vel[i];
        cm_acc[i]  = tr_acc[i];
        cv = cm_vel[i];
        ca = cm_acc[i];
        r = clip(-2 * cv + scaled(coef[REG_PRED_VEL_COEF], ca, 0));
        tr_vel[i] = r[DATA_W-1:0];
        sat |= r[DATA_W];
        r = clip(-2 * ca + scaled(coef[REG_PRED_ACC_COEF], cv, 0));
        tr_acc[i] = r[DATA_W-1:0];
        sat |= r[DATA_W];
      end
      KIND_CORRECT: begin
        d = req.disp_value;
        r = clip(wide_t'(tr_disp[i]) + d);
        tr_disp[i] = r[DATA_W-1:0];
        sat |= r[DATA_W];
        r = clip(wide_t'(tr_vel[i]) + scaled(coef[REG_VEL_GAIN], d, 0));
        tr_vel[i] = r[DATA_W-1:0];
        sat |= r[DATA_W];
        r = clip(wide_t'(tr_acc[i]) + scaled(coef[REG_ACC_GAIN], d, 0));
        tr_acc[i] = r[DATA_W-1:0];
        sat |= r[DATA_W];
      end
      KIND_COMMIT: begin
        cd = cm_disp[i];
        cv = cm_vel[i];
        ca = cm_acc[i];
        ta = tr_acc[i];
        // acceleration first: velocity and displacement use the new value
        r = clip(ca + scaled(coef[REG_INV_THETA], ta - ca, 0));
        tr_acc[i] = r[DATA_W-1:0];
        sat |= r[DATA_W];
        ta = tr_acc[i];
        r = clip(cv + scaled(coef[REG_HALF_DT], ta, 0) + scaled(coef[REG_HALF_DT], ca, 0));
        tr_vel[i] = r[DATA_W-1:0];
        sat |= r[DATA_W];
        r = clip(cd + scaled(coef[REG_STEP_DT], cv, 0) + scaled(coef[REG_DT_SQ_SIXTH], ta, 0)
                 + scaled(coef[REG_DT_SQ_SIXTH], ca, 1));
        tr_disp[i] = r[DATA_W-1:0];
        sat |= r[DATA_W];
      end
    endcase
    res.dof_out   = req.dof;
    res.disp_out  = tr_disp[i];
    res.vel_out   = tr_vel[i];
    res.acc_out   = tr_acc[i];
    res.saturated = sat;
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t seen, want, fresh;
    if (!rst_ni) begin
      foreach (coef[n]) coef[n] = '0;
      coef[REG_INV_THETA] = 32'sh0001_0000;
      expected_updates.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) coef[cfg_index_i] = cfg_data_i;
      if (out_valid_i && out_ready_i) begin
        seen = out_data_i;
        if (expected_updates.size() == 0) begin
          $error("unexpected result for dof %0d", seen.dof_out);
          fail_count++;
        end else begin
          want = expected_updates.pop_front();
          if (seen.dof_out !== want.dof_out) begin
            $error("dof_out: expected %0d, got %0d", want.dof_out, seen.dof_out);
            fail_count++;
          end
          if (seen.disp_out !== want.disp_out) begin
            $error("disp_out (dof %0d): expected %0d, got %0d",
                   want.dof_out, want.disp_out, seen.disp_out);
            fail_count++;
          end
          if (seen.vel_out !== want.vel_out) begin
            $error("vel_out (dof %0d): expected %0d, got %0d",
                   want.dof_out, want.vel_out, seen.vel_out);
            fail_count++;
          end
          if (seen.acc_out !== want.acc_out) begin
            $error("acc_out (dof %0d): expected %0d, got %0d",
                   want.dof_out, want.acc_out, seen.acc_out);
            fail_count++;
          end
          if (seen.saturated !== want.saturated) begin
            $error("saturated (dof %0d): expected %0d, got %0d",
                   want.dof_out, want.saturated, seen.saturated);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (next_trial_values(in_data_i, fresh)) expected_updates.push_back(fresh);
      end
    end
    waiting = expected_updates.size();
  end

endmodule

// File: bench/tb_wilson_theta_state_update.sv
`timescale 1ns / 1ps
// Testbench top for wilson_theta_state_update: clock, reset, request and
// config stimulus, receiver stalls and the verdict. Depends on wtsu_pkg, the
// block RTL and wtsu_state_checker, which predicts and compares results.

module tb_wilson_theta_state_update;
  import wtsu_pkg::*;

  localparam int          PHASE_COUNT  = 6;
  localparam int          PHASE_ITEMS  = 155;
  localparam int          DRAIN_CYCLES = 12;
  localparam int          HOLD_CYCLES  = 120;
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int          LAST_DOF     = DOF_DEPTH_DEF - 1;

  localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  int          fail_count;
  int          waiting;
  int unsigned cycle_count;

  // steady: no gaps on either side; hold_req: receiver goes quiet for a while
  bit steady;
  bit hold_req;

  // Track which DOFs hold trial / committed values so no unwritten entry is read
  bit               loaded    [DOF_DEPTH_DEF];
  bit               predicted [DOF_DEPTH_DEF];
  logic [DOF_W-1:0] hot_dofs  [16];

  wilson_theta_state_update u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  wtsu_state_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .waiting_o    (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Mostly back to back, some short gaps, a few long ones
  function automatic int gap_len();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Spread of magnitudes: full random, small, mid-range, and the edges
  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned       r;
    logic [DATA_W-1:0] mid_val;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom;
    if (r < 65) return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    if (r < 82) begin
      mid_val = $urandom >> $urandom_range(4, 16);
      return $urandom_range(0, 1) ? mid_val : -mid_val;
    end
    case ($urandom_range(0, 4))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      3:       return '1;
      default: return Q_ONE;
    endcase
  endfunction

  // Receiver: random stalls, plus one long hold-off on request so the block
  // backs up and stalls its input side
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (steady) begin
        out_ready <= 1'b1;
        @(negedge clk);
      end else begin
        stall = gap_len();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
  end

  // Offer one request after a random gap; return at the accepting edge with
  // valid still high so a following request can go out without a drop
  task automatic send_request(input in_item_t req);
    int gap;
    @(negedge clk);
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic issue(input kind_e k, input int unsigned dof,
                       input logic [DATA_W-1:0] d, input logic [DATA_W-1:0] v,
                       input logic [DATA_W-1:0] a);
    in_item_t req;
    req.kind       = k;
    req.dof        = DOF_W'(dof);
    req.disp_value = d;
    req.vel_value  = v;
    req.acc_value  = a;
    if (k == KIND_LOAD) loaded[dof] = 1'b1;
    if (k == KIND_PREDICT) predicted[dof] = 1'b1;
    send_request(req);
  endtask

  // Mostly revisit a few hot DOFs so load/predict/correct/commit chains form
  task automatic random_request();
    int unsigned r;
    int unsigned dof;
    kind_e       k;
    if ($urandom_range(0, 9) < 8) dof = hot_dofs[$urandom_range(0, 15)];
    else dof = $urandom_range(0, LAST_DOF);
    r = $urandom_range(0, 99);
    if (!loaded[dof] || r < 12) k = KIND_LOAD;
    else if (r < 37) k = KIND_PREDICT;
    else if (r < 72) k = KIND_CORRECT;
    else if (predicted[dof]) k = KIND_COMMIT;
    else k = KIND_PREDICT;
    issue(k, dof, pick_value(), pick_value(), pick_value());
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(input int p);
    logic [DATA_W-1:0] vals [8];
    int                n;
    case (p)
      0: begin
        // theta 1.4, dt 0.01
        vals[REG_INV_THETA]     = 32'd46811;
        vals[REG_PRED_VEL_COEF] = -32'd459;
        vals[REG_PRED_ACC_COEF] = -32'd28086857;
        vals[REG_VEL_GAIN]      = 32'd14043429;
        vals[REG_ACC_GAIN]      = 32'd2006200000;
        vals[REG_HALF_DT]       = 32'd328;
        vals[REG_STEP_DT]       = 32'd655;
        vals[REG_DT_SQ_SIXTH]   = 32'd1;
      end
      1: foreach (vals[n]) vals[n] = '0;
      2: foreach (vals[n]) vals[n] = Q_MAX;
      3: foreach (vals[n]) vals[n] = Q_MIN;
      4: foreach (vals[n]) vals[n] = $urandom;
      default: foreach (vals[n]) vals[n] = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
    endcase
    for (n = 0; n < 8; n++) write_reg(cfg_reg_e'(n), vals[n]);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait for every result, then let the block go fully idle
  task automatic end_phase();
    @(negedge clk);
    in_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Edge values under the reset constants: clipping on predict and correct,
  // both ends of the DOF range, alternating bit patterns
  task automatic run_directed();
    issue(KIND_LOAD, 0, Q_MAX, Q_MAX, Q_MAX);
    issue(KIND_LOAD, LAST_DOF, Q_MIN, Q_MIN, Q_MIN);
    issue(KIND_LOAD, 512, '0, '0, '0);
    issue(KIND_PREDICT, 0, pick_value(), pick_value(), pick_value());
    issue(KIND_PREDICT, LAST_DOF, pick_value(), pick_value(), pick_value());
    issue(KIND_PREDICT, 512, pick_value(), pick_value(), pick_value());
    issue(KIND_CORRECT, 0, Q_MAX, Q_MIN, Q_MAX);
    issue(KIND_CORRECT, LAST_DOF, Q_MIN, Q_MAX, Q_MIN);
    issue(KIND_CORRECT, 512, '1, '0, '1);
    issue(KIND_COMMIT, 0, '0, '0, '0);
    issue(KIND_COMMIT, LAST_DOF, '1, '1, '1);
    issue(KIND_COMMIT, 512, pick_value(), pick_value(), pick_value());
    issue(KIND_LOAD, 1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF);
    issue(KIND_PREDICT, 1, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000);
    issue(KIND_COMMIT, 1, pick_value(), pick_value(), pick_value());
    issue(KIND_LOAD, 1022, '1, Q_ONE, -Q_ONE);
    issue(KIND_CORRECT, 1022, Q_ONE, pick_value(), pick_value());
    issue(KIND_PREDICT, 1022, pick_value(), pick_value(), pick_value());
    issue(KIND_COMMIT, 1022, pick_value(), pick_value(), pick_value());
    issue(KIND_CORRECT, 1022, '0, pick_value(), pick_value());
  endtask

  initial begin : stimulus
    int p;
    int i;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    steady    = 1'b0;
    hold_req  = 1'b0;
    rst_n     = 1'b0;
    hot_dofs[0] = '0;
    hot_dofs[1] = DOF_W'(LAST_DOF);
    for (i = 2; i < 16; i++) hot_dofs[i] = DOF_W'($urandom_range(0, LAST_DOF));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();

    for (p = 0; p < PHASE_COUNT; p++) begin
      end_phase();
      apply_setting(p);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // a stretch with no gaps and no stalls in every phase
        steady = (i >= 90 && i < 120);
        if ((p == 1 || p == 4) && i == 40) hold_req = 1'b1;
        random_request();
      end
      steady = 1'b0;
    end
    end_phase();

    if (fail_count == 0 && waiting == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
